// ===== design/sha_pkg.sv =====
package sha_pkg;

	localparam int unsigned ROUNDS = 64;

	typedef logic [31:0] word_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LOAD  = 7'b0000010,
		ST_ROUND = 7'b0000100,
		ST_FOLD  = 7'b0001000,
		ST_PAD   = 7'b0010000,
		ST_LEN   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	localparam word_t [7:0] H_INIT = '{
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic word_t round_k(input logic [5:0] t);
		word_t k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

endpackage

// ===== design/sha_ram.sv =====
module sha_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== design/sha_round.sv =====
module sha_round (
	input  sha_pkg::word_t [7:0] v,
	input  sha_pkg::word_t       k,
	input  sha_pkg::word_t       w,
	output sha_pkg::word_t [7:0] v_next
);

	sha_pkg::word_t s0, s1, ch, maj, t1, t2;

	always_comb begin
		s1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^ {v[4][24:0], v[4][31:25]};
		ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
		t1 = v[7] + s1 + ch + k + w;
		s0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^ {v[0][21:0], v[0][31:22]};
		maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
		t2 = s0 + maj;
		v_next[7] = v[6];
		v_next[6] = v[5];
		v_next[5] = v[4];
		v_next[4] = v[3] + t1;
		v_next[3] = v[2];
		v_next[2] = v[1];
		v_next[1] = v[0];
		v_next[0] = t1 + t2;
	end

endmodule

// ===== design/sha256_stream_hasher.sv =====
// A byte that does not complete a block is taken while the block stays ready; a completing byte
// is followed by the byte-wide block RAM read, 64 rounds and the fold before the next transfer.
// A final item adds padding from the fill point, the eight length bytes and a compression;
// a spill into an extra block adds a block of zeros and one more compression. Four transfers follow.
// Input is stalled (s_tready low) outside the idle state, so no new byte is taken while a block
// is loaded, hashed, padded or output. Reset: asynchronous, active low; hash words reload, no clearing pass.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata, // data_byte[7:0]
	input  logic        s_tuser, // byte_present[0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata, // digest_part[63:0]
	output logic [1:0]  m_tuser, // part_index[1:0]
	output logic        m_tlast
);

	sha_pkg::state_t state_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic        last_q;
	logic        second_q;
	sha_pkg::word_t [7:0] h_q, v_q, v_next;
	sha_pkg::word_t [15:0] win_q;
	logic [6:0]  cnt_q;
	logic [5:0]  t_q;
	logic [1:0]  part_q;
	sha_pkg::word_t wacc_q;
	sha_pkg::word_t wacc_d;

	logic        wr_en;
	logic [5:0]  wr_addr, rd_addr;
	logic [7:0]  wr_data, rd_data;

	sha_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	sha_pkg::word_t w_cur, w2, w15, g0, g1;
	always_comb begin
		w2 = win_q[14];
		w15 = win_q[1];
		g1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
		g0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
		w_cur = (t_q < 6'd16) ? win_q[t_q[3:0]] : (g1 + win_q[9] + g0 + win_q[0]);
	end

	sha_round u_round (.v(v_q), .k(sha_pkg::round_k(t_q)), .w(w_cur), .v_next(v_next));

	logic acc;
	assign s_tready = (state_q == sha_pkg::ST_IDLE);
	assign acc = s_tvalid && s_tready;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = fill_q;
		wr_data = s_tdata;
		rd_addr = cnt_q[5:0];
		if (acc && s_tuser) begin
			wr_en = 1'b1;
		end else if (state_q == sha_pkg::ST_PAD) begin
			wr_en = 1'b1;
			wr_addr = cnt_q[5:0];
			wr_data = (cnt_q[5:0] == fill_q && !second_q) ? sha_pkg::PAD_BYTE : 8'h00;
		end else if (state_q == sha_pkg::ST_LEN) begin
			wr_en = 1'b1;
			wr_addr = {3'b111, cnt_q[2:0]};
			wr_data = bits_q[8*(7-cnt_q[2:0]) +: 8];
		end
	end

	logic [5:0] fill_inc;
	assign fill_inc = fill_q + 6'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::ST_IDLE;
			fill_q <= '0;
			bits_q <= '0;
			last_q <= 1'b0;
			second_q <= 1'b0;
			h_q <= sha_pkg::H_INIT;
			cnt_q <= '0;
			t_q <= '0;
			part_q <= '0;
		end else begin
			case (state_q)
				sha_pkg::ST_IDLE: begin
					if (acc) begin
						last_q <= s_tlast;
						second_q <= 1'b0;
						cnt_q <= '0;
						if (s_tuser) begin
							bits_q <= bits_q + 64'd8;
							fill_q <= fill_inc;
							if (fill_inc == 6'd0) begin
								state_q <= sha_pkg::ST_LOAD;
							end else if (s_tlast) begin
								cnt_q <= {1'b0, fill_q + 6'd1};
								state_q <= sha_pkg::ST_PAD;
							end
						end else if (s_tlast) begin
							cnt_q <= {1'b0, fill_q};
							state_q <= sha_pkg::ST_PAD;
						end
					end
				end
				sha_pkg::ST_PAD: begin
					// Bytes from the fill point to the end get 0x80 then zeros; in the block after a spill, all get zeros.
					if (cnt_q[5:0] == 6'd63) begin
						cnt_q <= '0;
						if (fill_q >= 6'd56 && !second_q) begin
							state_q <= sha_pkg::ST_LOAD;
						end else begin
							state_q <= sha_pkg::ST_LEN;
						end
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				sha_pkg::ST_LEN: begin
					if (cnt_q[2:0] == 3'd7) begin
						cnt_q <= '0;
						second_q <= 1'b1;
						state_q <= sha_pkg::ST_LOAD;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				sha_pkg::ST_LOAD: begin
					if (cnt_q == 7'd64) begin
						cnt_q <= '0;
						t_q <= '0;
						state_q <= sha_pkg::ST_ROUND;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				sha_pkg::ST_ROUND: begin
					t_q <= t_q + 6'd1;
					if (t_q == 6'(sha_pkg::ROUNDS - 1)) begin
						state_q <= sha_pkg::ST_FOLD;
					end
				end
				sha_pkg::ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					if (!last_q) begin
						state_q <= sha_pkg::ST_IDLE;
					end else if (!second_q) begin
						// After a spill the next block is zeros and the length; after a
						// full final block it starts with 0x80 at byte zero.
						second_q <= (fill_q >= 6'd56);
						cnt_q <= '0;
						state_q <= sha_pkg::ST_PAD;
					end else begin
						part_q <= '0;
						state_q <= sha_pkg::ST_OUT;
					end
				end
				sha_pkg::ST_OUT: begin
					if (m_tready) begin
						part_q <= part_q + 2'd1;
						if (part_q == 2'd3) begin
							h_q <= sha_pkg::H_INIT;
							fill_q <= '0;
							bits_q <= '0;
							last_q <= 1'b0;
							state_q <= sha_pkg::ST_IDLE;
						end
					end
				end
				default: state_q <= sha_pkg::ST_IDLE;
			endcase
		end
	end

	assign wacc_d = {wacc_q[23:0], rd_data};

	always_ff @(posedge clk) begin
		if (state_q == sha_pkg::ST_LOAD) begin
			if (cnt_q != 7'd0) begin
				wacc_q <= wacc_d;
				if (cnt_q[1:0] == 2'd0) begin
					win_q[cnt_q[5:2] - 4'd1] <= wacc_d;
				end
			end
			if (cnt_q == 7'd64) begin
				v_q <= h_q;
			end
		end else if (state_q == sha_pkg::ST_ROUND) begin
			v_q <= v_next;
			if (t_q >= 6'd16) begin
				for (int i = 0; i < 15; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[15] <= w_cur;
			end
		end
	end

	assign m_tvalid = (state_q == sha_pkg::ST_OUT);
	assign m_tdata = {h_q[{part_q, 1'b0}], h_q[{part_q, 1'b1}]};
	assign m_tuser = part_q;
	assign m_tlast = (part_q == 2'd3);

	a_out_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("output while accepting input");
	a_part_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 2'd1))
		else $error("digest parts out of order");
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha_pkg::ST_ROUND && t_q == 6'd63) |=> state_q == sha_pkg::ST_FOLD)
		else $error("round count broken");

endmodule
